/* hw/rtl/plrs_pkg.sv */
// shared types, codes and helpers for the log replication step unit
// no dependencies
package plrs_pkg;

  localparam int unsigned MAX_REPLICAS  = 8;
  localparam int unsigned REORDER_DEPTH = 16;
  localparam int unsigned VOTE_DEPTH    = 16;
  localparam int unsigned RIDX_W        = $clog2(REORDER_DEPTH);
  localparam int unsigned VIDX_W        = $clog2(VOTE_DEPTH);
  localparam int unsigned RCNT_W        = $clog2(REORDER_DEPTH + 1);
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned QUEUE_DEPTH   = 2;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_REPLY  = 2'd1,
    OP_COMMIT = 2'd2,
    OP_LOCAL  = 2'd3
  } op_e;

  localparam logic [1:0] KIND_NONE      = 2'd0;
  localparam logic [1:0] KIND_ACK       = 2'd1;
  localparam logic [1:0] KIND_COMMIT    = 2'd2;
  localparam logic [1:0] KIND_REPLICATE = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_VIEW     = 3'd1;
  localparam logic [2:0] ST_STALE    = 3'd2;
  localparam logic [2:0] ST_BUFFERED = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;
  localparam logic [2:0] ST_PENDING  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_REPLICA_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MY_REPLICA    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHARD_NUMBER  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_VIEW  = 2'd3;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_SCAN,
    BS_EMIT,
    BS_DRAIN
  } back_state_e;

  // configuration seen by the front and back parts
  typedef struct packed {
    logic [3:0]  replica_count;
    logic [2:0]  my_replica;
    logic [7:0]  shard_number;
    logic [31:0] current_view;
    logic [2:0]  leader;
    logic        busy;
  } cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    op_e         op;
    logic        mismatch;
    logic [31:0] batch;
    logic [2:0]  sender;
    logic [31:0] handle;
  } cmd_t;

  function automatic logic [31:0] min32(input logic [31:0] a, input logic [31:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [RIDX_W-1:0] rslot(input logic [31:0] id);
    logic [31:0] m;
    m = id % REORDER_DEPTH;
    return m[RIDX_W-1:0];
  endfunction

  function automatic logic [VIDX_W-1:0] vslot(input logic [31:0] id);
    logic [31:0] m;
    m = id % VOTE_DEPTH;
    return m[VIDX_W-1:0];
  endfunction

endpackage

/* hw/rtl/plrs_cfg.sv */
// configuration registers and bit-serial leader index computation
// depends on plrs_pkg
module plrs_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [plrs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  output plrs_pkg::cfg_t                 cfg_o
);
  import plrs_pkg::*;

  logic [3:0]  rc_q;
  logic [2:0]  me_q;
  logic [7:0]  shard_q;
  logic [31:0] view_q;
  logic [2:0]  leader_q;
  logic        start_q, busy_q, pass_q;
  logic [4:0]  cnt_q;
  logic [31:0] src_q;
  logic [3:0]  rem_q;

  logic [4:0]  trial, rc5, rem_next5;
  logic [8:0]  sum;

  assign cfg_ready_o = 1'b1;

  // one restoring remainder step per cycle
  assign trial     = {rem_q, src_q[31]};
  assign rc5       = {1'b0, rc_q};
  assign rem_next5 = (trial >= rc5) ? (trial - rc5) : trial;
  assign sum       = {5'b0, rem_next5[3:0]} + {1'b0, shard_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q     <= 4'd3;
      me_q     <= '0;
      shard_q  <= '0;
      view_q   <= '0;
      leader_q <= '0;
      start_q  <= 1'b0;
      busy_q   <= 1'b0;
      pass_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_REPLICA_COUNT: rc_q    <= cfg_data_i[3:0];
          CFG_MY_REPLICA:    me_q    <= cfg_data_i[2:0];
          CFG_SHARD_NUMBER:  shard_q <= cfg_data_i[7:0];
          CFG_CURRENT_VIEW:  view_q  <= cfg_data_i;
          default: ;
        endcase
      end
      start_q <= cfg_valid_i;
      if (start_q) begin
        busy_q <= 1'b1;
        pass_q <= 1'b0;
        cnt_q  <= 5'd31;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          if (!pass_q) begin
            // second pass covers only the nine bits of the sum
            pass_q <= 1'b1;
            cnt_q  <= 5'd8;
          end else begin
            busy_q   <= 1'b0;
            leader_q <= (rc_q == 4'd0) ? 3'd0 : rem_next5[2:0];
          end
        end
      end
    end
  end

  // datapath of the remainder unit
  always_ff @(posedge clk_i) begin
    if (start_q) begin
      src_q <= view_q;
      rem_q <= '0;
    end else if (busy_q) begin
      if (cnt_q == 5'd0 && !pass_q) begin
        src_q <= {sum, 23'b0};
        rem_q <= '0;
      end else begin
        src_q <= {src_q[30:0], 1'b0};
        rem_q <= rem_next5[3:0];
      end
    end
  end

  assign cfg_o = '{replica_count: rc_q, my_replica: me_q, shard_number: shard_q,
                   current_view: view_q, leader: leader_q, busy: start_q | busy_q};

endmodule

/* hw/rtl/plrs_queue.sv */
// two-entry request queue between front and back
// depends on plrs_pkg
module plrs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  plrs_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output plrs_pkg::cmd_t head_o
);
  import plrs_pkg::*;

  cmd_t       mem_q [QUEUE_DEPTH];
  logic       wr_q, rd_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'(QUEUE_DEPTH));
  assign valid_o = (count_q != 2'd0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

endmodule

/* hw/rtl/plrs_front.sv */
// front part: accepts requests, checks the view and forms queue entries
// depends on plrs_pkg
module plrs_front (
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [1:0]     operation_i,
  input  logic [31:0]    msg_view_i,
  input  logic [31:0]    batch_number_i,
  input  logic [2:0]     sender_replica_i,
  input  logic [31:0]    batch_handle_i,
  input  plrs_pkg::cfg_t cfg_i,
  input  logic           q_full_i,
  output logic           push_o,
  output plrs_pkg::cmd_t cmd_o
);
  import plrs_pkg::*;

  op_e op;

  assign op         = op_e'(operation_i);
  assign in_ready_o = !q_full_i && !cfg_i.busy;
  assign push_o     = in_valid_i && in_ready_o;

  // local appends carry no view
  assign cmd_o = '{op: op,
                   mismatch: (op != OP_LOCAL) && (msg_view_i != cfg_i.current_view),
                   batch: batch_number_i, sender: sender_replica_i,
                   handle: batch_handle_i};

endmodule

/* hw/rtl/plrs_back.sv */
// back part: log state, reorder and vote windows, result register
// depends on plrs_pkg
module plrs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  plrs_pkg::cfg_t cfg_i,
  input  logic           cmd_valid_i,
  input  plrs_pkg::cmd_t cmd_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [1:0]     kind_o,
  output logic [31:0]    out_batch_o,
  output logic [31:0]    out_handle_o,
  output logic [2:0]     target_o,
  output logic [2:0]     status_o,
  output logic [31:0]    prepared_now_o,
  output logic [31:0]    committed_now_o,
  output logic           last_o
);
  import plrs_pkg::*;

  back_state_e state_q, state_d;

  logic [31:0] prep_q, comm_q, cp_q;
  logic [REORDER_DEPTH-1:0] rvalid_q;
  logic [31:0] rid_q  [REORDER_DEPTH];
  logic [31:0] rref_q [REORDER_DEPTH];
  logic [VOTE_DEPTH-1:0] vvalid_q;
  logic [31:0] vid_q   [VOTE_DEPTH];
  logic [7:0]  vmask_q [VOTE_DEPTH];

  // pending primary result
  logic [1:0]  pk_q;
  logic [31:0] pb_q, ph_q, fin_prep_q, fin_comm_q, scan_q;
  logic [2:0]  pt_q, ps_q;
  logic [RCNT_W-1:0] cnt_q;

  logic out_free, exec, scan_hit, load_prim, load_drain;

  // execute decode
  logic [1:0]  ex_kind;
  logic [31:0] ex_batch, ex_handle, ex_prep, ex_comm, ex_cp, want, diff;
  logic [2:0]  ex_target, ex_status;
  logic        ex_rwr, ex_vwr, ex_vclr, ex_scan;
  logic [RIDX_W-1:0] rs, ss, ds;
  logic [VIDX_W-1:0] vs;
  logic [7:0]  vm;
  logic [3:0]  votes, need;
  logic [31:0] drain_id;

  assign out_free = !out_valid_o || out_ready_i;
  assign want     = prep_q + 32'd1;
  assign diff     = cmd_i.batch - want;
  assign rs       = rslot(cmd_i.batch);
  assign vs       = vslot(cmd_i.batch);
  assign vm       = ((vvalid_q[vs] && vid_q[vs] == cmd_i.batch) ? vmask_q[vs] : 8'd0)
                    | (8'd1 << cmd_i.sender);
  assign votes    = 4'($countones(vm));
  assign need     = {1'b0, cfg_i.replica_count[3:1]} + 4'd1;
  assign ss       = rslot(scan_q);
  assign scan_hit = rvalid_q[ss] && (rid_q[ss] == scan_q) &&
                    (cnt_q != RCNT_W'(REORDER_DEPTH));
  assign drain_id = prep_q + 32'd1;
  assign ds       = rslot(drain_id);

  always_comb begin
    ex_kind   = KIND_NONE;
    ex_batch  = cmd_i.batch;
    ex_handle = '0;
    ex_target = '0;
    ex_status = ST_OK;
    ex_prep   = prep_q;
    ex_comm   = comm_q;
    ex_cp     = cp_q;
    ex_rwr    = 1'b0;
    ex_vwr    = 1'b0;
    ex_vclr   = 1'b0;
    ex_scan   = 1'b0;
    if (cmd_i.mismatch) begin
      ex_status = ST_VIEW;
    end else begin
      case (cmd_i.op)
        OP_APPEND: begin
          ex_scan = 1'b1;
          if (cmd_i.batch == want) begin
            ex_prep   = want;
            ex_comm   = min32(want, cp_q);
            ex_kind   = KIND_ACK;
            ex_handle = cmd_i.handle;
            ex_target = cfg_i.leader;
          end else if (cmd_i.batch > want) begin
            if (diff <= 32'(REORDER_DEPTH)) begin
              ex_rwr    = 1'b1;
              ex_status = ST_BUFFERED;
            end else begin
              ex_status = ST_OVERFLOW;
            end
          end else begin
            ex_status = ST_STALE;
          end
        end
        OP_REPLY: begin
          if (cmd_i.batch <= comm_q) begin
            ex_status = ST_STALE;
          end else if (cmd_i.batch - comm_q > 32'(VOTE_DEPTH)) begin
            ex_status = ST_OVERFLOW;
          end else if (votes >= need) begin
            ex_vclr = 1'b1;
            ex_comm = cmd_i.batch;
            ex_cp   = cmd_i.batch;
            ex_kind = KIND_COMMIT;
          end else begin
            ex_vwr    = 1'b1;
            ex_status = ST_PENDING;
          end
        end
        OP_COMMIT: begin
          if (cmd_i.batch <= cp_q) begin
            ex_status = ST_STALE;
          end else begin
            ex_cp   = cmd_i.batch;
            ex_comm = min32(prep_q, cmd_i.batch);
          end
        end
        default: begin
          ex_prep   = want;
          ex_kind   = KIND_REPLICATE;
          ex_batch  = want;
          ex_handle = cmd_i.handle;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BS_IDLE:  if (cmd_valid_i) state_d = ex_scan ? BS_SCAN : BS_EMIT;
      BS_SCAN:  if (!scan_hit) state_d = BS_EMIT;
      BS_EMIT:  if (out_free) state_d = (cnt_q == '0) ? BS_IDLE : BS_DRAIN;
      BS_DRAIN: if (out_free && cnt_q == RCNT_W'(1)) state_d = BS_IDLE;
      default:  state_d = BS_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    exec       = 1'b0;
    load_prim  = 1'b0;
    load_drain = 1'b0;
    case (state_q)
      BS_IDLE:  exec = cmd_valid_i;
      BS_EMIT:  load_prim = out_free;
      BS_DRAIN: load_drain = out_free;
      default: ;
    endcase
  end

  assign pop_o = exec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      prep_q      <= '0;
      comm_q      <= '0;
      cp_q        <= '0;
      rvalid_q    <= '0;
      vvalid_q    <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec) begin
        prep_q <= ex_prep;
        comm_q <= ex_comm;
        cp_q   <= ex_cp;
        if (ex_rwr) rvalid_q[rs] <= 1'b1;
        if (ex_vwr) vvalid_q[vs] <= 1'b1;
        if (ex_vclr) vvalid_q[vs] <= 1'b0;
      end
      if (load_drain) begin
        rvalid_q[ds] <= 1'b0;
        prep_q       <= drain_id;
        comm_q       <= min32(drain_id, cp_q);
      end
      if (load_prim || load_drain) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      pk_q       <= ex_kind;
      pb_q       <= ex_batch;
      ph_q       <= ex_handle;
      pt_q       <= ex_target;
      ps_q       <= ex_status;
      fin_prep_q <= ex_prep;
      fin_comm_q <= ex_comm;
      scan_q     <= ex_prep + 32'd1;
      cnt_q      <= '0;
      if (ex_rwr) begin
        rid_q[rs]  <= cmd_i.batch;
        rref_q[rs] <= cmd_i.handle;
      end
      if (ex_vwr) begin
        vid_q[vs]   <= cmd_i.batch;
        vmask_q[vs] <= vm;
      end
    end
    // count the run of buffered batches that will drain
    if (state_q == BS_SCAN) begin
      if (scan_hit) begin
        scan_q <= scan_q + 32'd1;
        cnt_q  <= cnt_q + RCNT_W'(1);
      end else if (cnt_q != '0) begin
        fin_prep_q <= prep_q + 32'(cnt_q);
        fin_comm_q <= min32(prep_q + 32'(cnt_q), cp_q);
      end
    end
    if (load_drain) cnt_q <= cnt_q - RCNT_W'(1);
    if (load_prim) begin
      kind_o          <= pk_q;
      out_batch_o     <= pb_q;
      out_handle_o    <= ph_q;
      target_o        <= pt_q;
      status_o        <= ps_q;
      prepared_now_o  <= fin_prep_q;
      committed_now_o <= fin_comm_q;
      last_o          <= (cnt_q == '0);
    end else if (load_drain) begin
      kind_o          <= KIND_ACK;
      out_batch_o     <= drain_id;
      out_handle_o    <= rref_q[ds];
      target_o        <= cfg_i.leader;
      status_o        <= ST_OK;
      prepared_now_o  <= fin_prep_q;
      committed_now_o <= fin_comm_q;
      last_o          <= (cnt_q == RCNT_W'(1));
    end
  end

endmodule

/* hw/rtl/paxos_log_replication_step_unit.sv */
// top level of the log replication step unit
// depends on plrs_pkg, plrs_cfg, plrs_front, plrs_queue, plrs_back
//
// channel   direction  handshake               payload
// in        input      in_valid_i/in_ready_o   operation, view, batch, sender, handle
// out       output     out_valid_o/out_ready_i kind, batch, handle, target, status, ids, last
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// a request passes through the execute and emit states of the back part; an append
// also scans its reorder window once per released batch plus a final miss and then
// emits one ack per released batch, one a cycle unless the output stalls
// after reset the leader index is zero; after any config write it is rebuilt
// by a bit-serial remainder unit, and in_ready_o stays low until it is done
// the front keeps accepting into a two-entry queue, until it fills, while the
// back part stalls on a full result register
module paxos_log_replication_step_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     operation_i,
  input  logic [31:0]                    msg_view_i,
  input  logic [31:0]                    batch_number_i,
  input  logic [2:0]                     sender_replica_i,
  input  logic [31:0]                    batch_handle_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     kind_o,
  output logic [31:0]                    out_batch_o,
  output logic [31:0]                    out_handle_o,
  output logic [2:0]                     target_o,
  output logic [2:0]                     status_o,
  output logic [31:0]                    prepared_now_o,
  output logic [31:0]                    committed_now_o,
  output logic                           last_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [plrs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);
  import plrs_pkg::*;

  cfg_t cfg;
  cmd_t push_cmd, head_cmd;
  logic push, q_full, q_valid, pop;

  // config registers and leader index
  plrs_cfg u_cfg (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .cfg_o(cfg)
  );

  // view check and request intake
  plrs_front u_front (
    .in_valid_i, .in_ready_o, .operation_i, .msg_view_i, .batch_number_i,
    .sender_replica_i, .batch_handle_i, .cfg_i(cfg), .q_full_i(q_full),
    .push_o(push), .cmd_o(push_cmd)
  );

  // decouples intake from the state update
  plrs_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_cmd), .full_o(q_full),
    .pop_i(pop), .valid_o(q_valid), .head_o(head_cmd)
  );

  // log state, windows and result register
  plrs_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg), .cmd_valid_i(q_valid), .cmd_i(head_cmd),
    .pop_o(pop), .out_valid_o, .out_ready_i, .kind_o, .out_batch_o, .out_handle_o,
    .target_o, .status_o, .prepared_now_o, .committed_now_o, .last_o
  );

endmodule

/* hw/rtl/plrs_checker.sv */
// port-level checks for the log replication step unit, bound to the top level
// depends on plrs_pkg
module plrs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  kind_o,
  input logic [31:0] out_batch_o,
  input logic [2:0]  status_o,
  input logic [31:0] committed_now_o,
  input logic        last_o
);
  import plrs_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_batch_o))
    else $error("result changed while stalled");

  a_ack_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_ACK |-> status_o == ST_OK)
    else $error("ack with non-ok status");

  a_commit_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_COMMIT |-> committed_now_o == out_batch_o)
    else $error("commit broadcast disagrees with committed id");

  a_drain_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> !out_valid_o || kind_o == KIND_ACK)
    else $error("non-final result not followed by a drain ack");

endmodule

bind paxos_log_replication_step_unit plrs_checker u_plrs_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .kind_o, .out_batch_o, .status_o,
  .committed_now_o, .last_o
);
